// ===== hw/rtl/mvss_pkg.sv =====
`timescale 1ns / 1ps
package mvss_pkg;

    localparam int VOICES       = 8;
    localparam int VOICE_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_W       = $clog2(SINE_ENTRIES);

    localparam logic [31:0] SIN_C1 = 32'd26353589;
    localparam logic [31:0] SIN_C3 = 32'd10837478;
    localparam logic [31:0] SIN_C5 = 32'd1337020;
    localparam logic [31:0] SIN_C7 = 32'd78546;

    localparam logic [15:0] NOISE_SEED = 16'hACE1;
    localparam logic [15:0] NOISE_TAPS = 16'hB400;

    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_SAW    = 3'd1;
    localparam logic [2:0] WAVE_SQUARE = 3'd2;
    localparam logic [2:0] WAVE_NOISE  = 3'd3;
    localparam logic [2:0] WAVE_FM     = 3'd4;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    // Quarter-wave polynomial sine value at a table index, Q1.15
    function automatic logic signed [17:0] sine_value(input logic [SINE_W-1:0] idx);
        logic [63:0] pos;
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        pos  = ({52'd0, 12'(idx)} << 18) / SINE_ENTRIES;
        quad = pos[17:16];
        r    = {48'd0, pos[15:0]};
        x    = quad[0] ? (64'd65536 - r) : r;
        x2   = (x * x) >> 16;
        t    = ({32'd0, SIN_C7} * x2) >> 16;
        t    = {32'd0, SIN_C5} - t;
        t    = (t * x2) >> 16;
        t    = {32'd0, SIN_C3} - t;
        t    = (t * x2) >> 16;
        t    = {32'd0, SIN_C1} - t;
        t    = (t * x) >> 16;
        v    = (t + 64'd256) >> 9;
        sine_value = quad[1] ? -$signed(18'(v)) : $signed(18'(v));
    endfunction

endpackage

// ===== hw/rtl/multi_voice_sound_synth_unit.sv =====
`timescale 1ns / 1ps
// Trigger: result valid the cycle after acceptance; the idle-voice search is combinational.
// Tick: active voices step through carrier lookup, drive, filter, level, glide and update
// (FM: modulator lookup first) on one shared 33x25 multiplier and the registered sine table.
// One transaction in flight; ready returns the cycle after the result transaction.
// aresetn (synchronous, active low) clears voice valid bits, the sequencer and
// the noise LFSR (0xACE1); voice parameter stores are not reset.
module multi_voice_sound_synth_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[0], wave_kind[3:1], start_increment[35:4], target_increment[67:36],
    // glide_rate[91:68], start_level[115:92], level_step[139:116],
    // length_samples[163:140], smoothing[179:164], drive[195:180],
    // mod_depth[211:196], mod_increment[243:212], zero fill[247:244]
    input  logic [247:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mix_sample[15:0], started[16], voice_slot[19:17], zero fill[23:20]
    output logic [23:0]  m_tdata
);

    localparam int VW = mvss_pkg::VOICE_W;
    localparam int SW = mvss_pkg::SINE_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_MOD   = 4'd2;
    localparam logic [3:0] ST_MODW  = 4'd3;
    localparam logic [3:0] ST_FMUL  = 4'd4;
    localparam logic [3:0] ST_CAR   = 4'd5;
    localparam logic [3:0] ST_CARW  = 4'd6;
    localparam logic [3:0] ST_DRV   = 4'd7;
    localparam logic [3:0] ST_FILT  = 4'd8;
    localparam logic [3:0] ST_LVL   = 4'd9;
    localparam logic [3:0] ST_GLIDE = 4'd10;
    localparam logic [3:0] ST_UPD   = 4'd11;
    localparam logic [3:0] ST_MIX   = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    // Voice stores
    logic [mvss_pkg::VOICES-1:0] on_reg;
    logic [2:0]  wave_mem  [mvss_pkg::VOICES];
    logic [31:0] cph_mem   [mvss_pkg::VOICES];
    logic [31:0] cstep_mem [mvss_pkg::VOICES];
    logic [31:0] goal_mem  [mvss_pkg::VOICES];
    logic [23:0] glide_mem [mvss_pkg::VOICES];
    logic [23:0] lvl_mem   [mvss_pkg::VOICES];
    logic [23:0] dec_mem   [mvss_pkg::VOICES];
    logic [23:0] left_mem  [mvss_pkg::VOICES];
    logic [15:0] fc_mem    [mvss_pkg::VOICES];
    logic signed [15:0] fmem_mem [mvss_pkg::VOICES];
    logic [15:0] drv_mem   [mvss_pkg::VOICES];
    logic [15:0] fma_mem   [mvss_pkg::VOICES];
    logic [31:0] mph_mem   [mvss_pkg::VOICES];
    logic [31:0] mstep_mem [mvss_pkg::VOICES];

    logic [3:0]  state_reg;
    logic [VW:0] vidx_reg;
    logic [15:0] lfsr_reg;
    logic signed [47:0] acc_reg;
    logic signed [31:0] s_reg;
    logic [31:0] off_reg;
    logic signed [15:0] mix_reg;
    logic        started_reg;
    logic [2:0]  slot_reg;
    logic [23:0] lvl_new_reg;
    logic [31:0] step_new_reg;

    logic [VW-1:0] vi;
    assign vi = vidx_reg[VW-1:0];

    // Sine table shared by modulator and carrier lookups
    logic [SW-1:0]      rom_addr;
    logic signed [17:0] rom_data;
    mvss_sine_rom u_rom (.aclk(aclk), .addr(rom_addr), .data_reg(rom_data));

    logic [31:0] car_phase;
    assign car_phase = cph_mem[vi] + ((wave_mem[vi] == mvss_pkg::WAVE_FM) ? off_reg : 32'd0);
    assign rom_addr = (state_reg == ST_MOD || state_reg == ST_MODW) ? mph_mem[vi][31 -: SW]
                                                                    : car_phase[31 -: SW];

    // Shared multiplier: signed 33 x 25
    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [57:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [31:0] goal_v, step_v, gdiff;
    assign goal_v = goal_mem[vi];
    assign step_v = cstep_mem[vi];
    assign gdiff  = (goal_v >= step_v) ? goal_v - step_v : step_v - goal_v;

    logic signed [31:0] fdiff;
    assign fdiff = s_reg - 32'(fmem_mem[vi]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FMUL: begin
                mul_a = 33'(rom_data);
                mul_b = $signed({9'd0, fma_mem[vi]});
            end
            ST_DRV: begin
                mul_a = 33'(s_reg);
                mul_b = $signed({9'd0, drv_mem[vi]});
            end
            ST_FILT: begin
                mul_a = 33'(fdiff);
                mul_b = $signed({9'd0, fc_mem[vi]});
            end
            ST_LVL: begin
                mul_a = 33'(fmem_mem[vi]);
                mul_b = $signed({1'b0, lvl_mem[vi]});
            end
            ST_GLIDE: begin
                mul_a = $signed({1'b0, gdiff});
                mul_b = $signed({1'b0, glide_mem[vi]});
            end
            default: ;
        endcase
    end

    // Noise: LFSR step, remainder by 201 through a reciprocal multiply
    logic [15:0] lfsr_nx;
    assign lfsr_nx = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ mvss_pkg::NOISE_TAPS) : (lfsr_reg >> 1);
    logic [32:0] nq_prod;
    logic [15:0] nmod;
    logic [15:0] nmod_reg;
    logic signed [31:0] nval;
    assign nq_prod = {17'd0, lfsr_nx} * 33'd83470;
    assign nmod    = lfsr_nx - ({7'd0, nq_prod[32:24]} * 16'd201);

    // Scale the centered remainder to Q1.15, truncating toward zero
    always_comb begin
        nval = '0;
        for (int k = 0; k < 201; k++) begin
            if (nmod_reg == 16'(k)) begin
                nval = 32'(((k - 100) * 32768) / 100);
            end
        end
    end

    // Raw sample after carrier lookup
    logic signed [31:0] raw;
    always_comb begin
        case (wave_mem[vi]) inside
            mvss_pkg::WAVE_SINE, mvss_pkg::WAVE_FM: raw = 32'(rom_data);
            mvss_pkg::WAVE_SAW:    raw = $signed({16'd0, cph_mem[vi][31:16]}) - 32'sd32768;
            mvss_pkg::WAVE_SQUARE: raw = cph_mem[vi][31] ? -32'sd32768 : 32'sd32768;
            mvss_pkg::WAVE_NOISE:  raw = nval;
            default:               raw = '0;
        endcase
    end

    logic signed [57:0] drv_sh, filt_sh;
    assign drv_sh  = mul_p >>> 12;
    assign filt_sh = mul_p >>> 15;
    logic signed [57:0] fnew;
    assign fnew = 58'(fmem_mem[vi]) + filt_sh;

    // First idle voice
    logic [VW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = mvss_pkg::VOICES - 1; k >= 0; k--) begin
            if (!on_reg[k]) begin
                free_idx = VW'(k);
                free_any = 1'b1;
            end
        end
    end

    logic take_voice;
    assign take_voice = (s_tdata[0] == mvss_pkg::OP_TRIGGER) && free_any;

    logic signed [47:0] mix_sh;
    assign mix_sh = acc_reg >>> 23;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'd0, slot_reg, started_reg, mix_reg};

    logic [23:0] left_dec;
    assign left_dec = (left_mem[vi] != 24'd0) ? left_mem[vi] - 24'd1 : 24'd0;

    // Sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            on_reg    <= '0;
            lfsr_reg  <= mvss_pkg::NOISE_SEED;
            vidx_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mix_reg     <= '0;
                        started_reg <= take_voice;
                        slot_reg    <= take_voice ? 3'(free_idx) : 3'd0;
                        acc_reg     <= '0;
                        vidx_reg    <= '0;
                        if (s_tdata[0] == mvss_pkg::OP_TRIGGER) begin
                            if (free_any) begin
                                on_reg[free_idx]    <= 1'b1;
                                wave_mem[free_idx]  <= s_tdata[3:1];
                                cstep_mem[free_idx] <= s_tdata[35:4];
                                goal_mem[free_idx]  <= s_tdata[67:36];
                                glide_mem[free_idx] <= s_tdata[91:68];
                                lvl_mem[free_idx]   <= s_tdata[115:92];
                                dec_mem[free_idx]   <= s_tdata[139:116];
                                left_mem[free_idx]  <= s_tdata[163:140];
                                fc_mem[free_idx]    <= s_tdata[179:164];
                                drv_mem[free_idx]   <= s_tdata[195:180];
                                fma_mem[free_idx]   <= s_tdata[211:196];
                                mstep_mem[free_idx] <= s_tdata[243:212];
                                cph_mem[free_idx]   <= '0;
                                mph_mem[free_idx]   <= '0;
                                fmem_mem[free_idx]  <= '0;
                            end
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    off_reg <= '0;
                    if (vidx_reg == (VW+1)'(mvss_pkg::VOICES)) begin
                        state_reg <= ST_MIX;
                    end else if (!on_reg[vi]) begin
                        vidx_reg <= vidx_reg + 1'b1;
                    end else if (wave_mem[vi] == mvss_pkg::WAVE_FM) begin
                        state_reg <= ST_MOD;
                    end else begin
                        state_reg <= ST_CAR;
                    end
                end
                ST_MOD:  state_reg <= ST_MODW;
                ST_MODW: state_reg <= ST_FMUL;
                ST_FMUL: begin
                    off_reg   <= 32'(mul_p <<< 5);
                    state_reg <= ST_CAR;
                end
                ST_CAR: begin
                    nmod_reg  <= nmod;
                    state_reg <= ST_CARW;
                end
                ST_CARW: begin
                    s_reg <= raw;
                    if (wave_mem[vi] == mvss_pkg::WAVE_NOISE) begin
                        lfsr_reg <= lfsr_nx;
                    end
                    state_reg <= ST_DRV;
                end
                ST_DRV: begin
                    if (drv_mem[vi] > 16'd4096) begin
                        if (drv_sh > 58'sd32768) begin
                            s_reg <= 32'sd32768;
                        end else if (drv_sh < -58'sd32768) begin
                            s_reg <= -32'sd32768;
                        end else begin
                            s_reg <= 32'(drv_sh);
                        end
                    end
                    state_reg <= ST_FILT;
                end
                ST_FILT: begin
                    if (fnew > 58'sd32767) begin
                        fmem_mem[vi] <= 16'sh7fff;
                    end else if (fnew < -58'sd32768) begin
                        fmem_mem[vi] <= -16'sh8000;
                    end else begin
                        fmem_mem[vi] <= 16'(fnew);
                    end
                    state_reg <= ST_LVL;
                end
                ST_LVL: begin
                    acc_reg     <= acc_reg + 48'(mul_p);
                    lvl_new_reg <= (dec_mem[vi] >= lvl_mem[vi]) ? 24'd0 : lvl_mem[vi] - dec_mem[vi];
                    state_reg   <= ST_GLIDE;
                end
                ST_GLIDE: begin
                    step_new_reg <= (goal_v >= step_v) ? step_v + 32'(mul_p >>> 24)
                                                       : step_v - 32'(mul_p >>> 24);
                    state_reg    <= ST_UPD;
                end
                ST_UPD: begin
                    lvl_mem[vi]   <= lvl_new_reg;
                    cstep_mem[vi] <= step_new_reg;
                    cph_mem[vi]   <= cph_mem[vi] + step_new_reg;
                    mph_mem[vi]   <= mph_mem[vi] + mstep_mem[vi];
                    left_mem[vi]  <= left_dec;
                    if (left_dec == 24'd0 || lvl_new_reg == 24'd0) begin
                        on_reg[vi] <= 1'b0;
                    end
                    vidx_reg  <= vidx_reg + 1'b1;
                    state_reg <= ST_SCAN;
                end
                ST_MIX: begin
                    if (mix_sh > 48'sd32767) begin
                        mix_reg <= 16'sh7fff;
                    end else if (mix_sh < -48'sd32768) begin
                        mix_reg <= -16'sh8000;
                    end else begin
                        mix_reg <= 16'(mix_sh);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Checks
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready while result pending");
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed before taken");
    a_tick_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MIX) |=> !started_reg) else $error("tick flagged start");

endmodule

// ===== hw/rtl/mvss_sine_rom.sv =====
`timescale 1ns / 1ps
module mvss_sine_rom (
    input  logic                           aclk,
    input  logic [mvss_pkg::SINE_W-1:0]    addr,
    output logic signed [17:0]             data_reg
);

    logic signed [17:0] rom [mvss_pkg::SINE_ENTRIES];

    // Build the constant table
    always_comb begin
        for (int k = 0; k < mvss_pkg::SINE_ENTRIES; k++) begin
            rom[k] = mvss_pkg::sine_value(mvss_pkg::SINE_W'(k));
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        data_reg <= rom[addr];
    end

endmodule
